// ===== rtl/dae_pkg.sv =====
package dae_pkg;

    // Input beat: one packet byte in wire order
    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_packet;
    } in_beat_t;

    // Output beat: one report
    typedef struct packed {
        logic [2:0]  report_kind;
        logic [15:0] report_value;
        logic [3:0]  address_byte_index;
        logic        last_of_run;
    } out_beat_t;

    // Parser result handed to the output register
    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } parse_res_t;

    // Report kinds
    localparam logic [2:0] KIND_ID       = 3'd0;
    localparam logic [2:0] KIND_NO_ANSW  = 3'd1;
    localparam logic [2:0] KIND_IPV4     = 3'd2;
    localparam logic [2:0] KIND_IPV6     = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;

    // Parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_QNAME  = 3'd1;
    localparam logic [2:0] PH_QFIXED = 3'd2;
    localparam logic [2:0] PH_ANSWER = 3'd3;
    localparam logic [2:0] PH_RDATA  = 3'd4;
    localparam logic [2:0] PH_IDLE   = 3'd5;

    // Rdata handling
    localparam logic [1:0] RD_SKIP = 2'd0;
    localparam logic [1:0] RD_IPV4 = 2'd1;
    localparam logic [1:0] RD_IPV6 = 2'd2;

    // Field positions
    localparam logic [3:0] POS_ID_LO     = 4'd1;
    localparam logic [3:0] POS_ANCOUNT   = 4'd7;
    localparam logic [3:0] POS_HDR_LAST  = 4'd11;
    localparam logic [3:0] POS_QF_LAST   = 4'd3;
    localparam logic [3:0] POS_TYPE_LO   = 4'd3;
    localparam logic [3:0] POS_ANS_LAST  = 4'd11;

    // Record types and address lengths
    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] TYPE_AAAA = 16'd28;
    localparam logic [15:0] LEN_A     = 16'd4;
    localparam logic [15:0] LEN_AAAA  = 16'd16;

endpackage

// ===== rtl/dae_parser.sv =====
module dae_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  dae_pkg::in_beat_t beat,
    output dae_pkg::parse_res_t res
);

    logic [2:0]  phase_reg,   phase_next;
    logic [3:0]  pos_reg,     pos_next;
    logic [15:0] answers_reg, answers_next;
    logic [15:0] type_reg,    type_next;
    logic [15:0] rdata_reg,   rdata_next;
    logic [15:0] shift_reg,   shift_next;
    logic [1:0]  rdkind_reg,  rdkind_next;
    logic [1:0]  rdkind_new;

    // Step the parser by one byte
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        answers_next = answers_reg;
        type_next    = type_reg;
        rdata_next   = rdata_reg;
        rdkind_next  = rdkind_reg;
        rdkind_new   = dae_pkg::RD_SKIP;
        shift_next   = {shift_reg[7:0], beat.byte_value};
        res          = '0;

        case (phase_reg)
            dae_pkg::PH_HEADER: begin
                if (pos_reg == dae_pkg::POS_ID_LO) begin
                    res.valid                   = 1'b1;
                    res.beat.report_kind        = dae_pkg::KIND_ID;
                    res.beat.report_value       = shift_next;
                    res.beat.last_of_run        = 1'b1;
                end else if (pos_reg == dae_pkg::POS_ANCOUNT) begin
                    answers_next = shift_next;
                end
                if (pos_reg >= dae_pkg::POS_HDR_LAST) begin
                    pos_next = '0;
                    if (answers_reg == '0) begin
                        res.valid            = 1'b1;
                        res.beat.report_kind = dae_pkg::KIND_NO_ANSW;
                        res.beat.last_of_run = 1'b1;
                        phase_next           = dae_pkg::PH_IDLE;
                    end else begin
                        phase_next = dae_pkg::PH_QNAME;
                    end
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            dae_pkg::PH_QNAME: begin
                // skip the question name up to its zero byte
                if (beat.byte_value == 8'd0) begin
                    pos_next   = '0;
                    phase_next = dae_pkg::PH_QFIXED;
                end
            end
            dae_pkg::PH_QFIXED: begin
                if (pos_reg >= dae_pkg::POS_QF_LAST) begin
                    pos_next   = '0;
                    phase_next = dae_pkg::PH_ANSWER;
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            dae_pkg::PH_ANSWER: begin
                if (pos_reg == dae_pkg::POS_TYPE_LO) begin
                    type_next = shift_next;
                end
                if (pos_reg >= dae_pkg::POS_ANS_LAST) begin
                    rdata_next = shift_next;
                    pos_next   = '0;
                    if (type_reg == dae_pkg::TYPE_A && shift_next == dae_pkg::LEN_A) begin
                        rdkind_new = dae_pkg::RD_IPV4;
                    end else if (type_reg == dae_pkg::TYPE_AAAA &&
                                 shift_next == dae_pkg::LEN_AAAA) begin
                        rdkind_new = dae_pkg::RD_IPV6;
                    end else begin
                        rdkind_new                  = dae_pkg::RD_SKIP;
                        res.valid                   = 1'b1;
                        res.beat.report_kind        = dae_pkg::KIND_OTHER;
                        res.beat.report_value       = type_reg;
                        res.beat.last_of_run        = 1'b1;
                    end
                    rdkind_next = rdkind_new;
                    if (shift_next == '0) begin
                        // empty rdata: the answer ends here
                        answers_next = answers_reg - 16'd1;
                        rdkind_next  = dae_pkg::RD_SKIP;
                        phase_next   = (answers_reg == 16'd1) ? dae_pkg::PH_IDLE
                                                              : dae_pkg::PH_ANSWER;
                    end else begin
                        phase_next = dae_pkg::PH_RDATA;
                    end
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            dae_pkg::PH_RDATA: begin
                if (rdkind_reg == dae_pkg::RD_IPV4 || rdkind_reg == dae_pkg::RD_IPV6) begin
                    res.valid                   = 1'b1;
                    res.beat.report_kind        = (rdkind_reg == dae_pkg::RD_IPV4) ?
                                                  dae_pkg::KIND_IPV4 : dae_pkg::KIND_IPV6;
                    res.beat.report_value       = {8'd0, beat.byte_value};
                    res.beat.address_byte_index = pos_reg;
                    res.beat.last_of_run        = (rdata_reg == 16'd1);
                end
                rdata_next = rdata_reg - 16'd1;
                pos_next   = pos_reg + 4'd1;
                if (rdata_reg == 16'd1) begin
                    answers_next = answers_reg - 16'd1;
                    pos_next     = '0;
                    rdkind_next  = dae_pkg::RD_SKIP;
                    phase_next   = (answers_reg == 16'd1) ? dae_pkg::PH_IDLE
                                                          : dae_pkg::PH_ANSWER;
                end
            end
            default: begin
            end
        endcase

        // end of packet: back to the header with all state cleared
        if (beat.end_of_packet) begin
            phase_next   = dae_pkg::PH_HEADER;
            pos_next     = '0;
            answers_next = '0;
            type_next    = '0;
            rdata_next   = '0;
            shift_next   = '0;
            rdkind_next  = dae_pkg::RD_SKIP;
        end

        res.valid = res.valid & step;
    end

    // Hold parser state between beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= dae_pkg::PH_HEADER;
            pos_reg     <= '0;
            answers_reg <= '0;
            type_reg    <= '0;
            rdata_reg   <= '0;
            shift_reg   <= '0;
            rdkind_reg  <= dae_pkg::RD_SKIP;
        end else if (step) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            answers_reg <= answers_next;
            type_reg    <= type_next;
            rdata_reg   <= rdata_next;
            shift_reg   <= shift_next;
            rdkind_reg  <= rdkind_next;
        end
    end

    // Rdata phase is only ever entered with bytes left to take
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == dae_pkg::PH_RDATA |-> rdata_reg != '0)
        else $error("rdata phase with no bytes left");

    // End of packet returns the parser to header start
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && beat.end_of_packet |=> phase_reg == dae_pkg::PH_HEADER && pos_reg == '0)
        else $error("end of packet did not restart the header");

    // IPv4 run closes on its fourth byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.beat.report_kind == dae_pkg::KIND_IPV4 |->
        res.beat.address_byte_index <= 4'd3 &&
        res.beat.last_of_run == (res.beat.address_byte_index == 4'd3))
        else $error("IPv4 byte index or last flag wrong");

    // IPv6 run closes on its sixteenth byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.beat.report_kind == dae_pkg::KIND_IPV6 |->
        res.beat.last_of_run == (res.beat.address_byte_index == 4'd15))
        else $error("IPv6 last flag wrong");

endmodule

// ===== rtl/dae_out_reg.sv =====
module dae_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  dae_pkg::parse_res_t  res,
    output logic                 free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dae_pkg::out_beat_t   m_data
);

    logic               valid_reg;
    dae_pkg::out_beat_t data_reg;

    // Take a new result when empty or when the current one leaves
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= res.valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload loads only with a real result
    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            data_reg <= res.beat;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/dns_answer_address_extractor.sv =====
// DNS response answer address extractor.
// Input channel (s_valid/s_ready/s_data): one response byte per beat in wire
// order, with end_of_packet set on the packet's last byte.
// Output channel (m_valid/m_ready/m_data): at most one report per input beat:
// the response id, a "no answers" notice, IPv4/IPv6 address bytes with their
// index and a last-of-run flag, or the type of any other answer record.
// Path: each byte passes the input register, then the parser logic, then the
// result register, whose output drives m_valid; a receiver stall can hold a
// byte in either register.
// Throughput: one byte per cycle while m_ready stays high; the parser state
// update for a byte is combinational logic between the two registers.
// Reset (aresetn low, synchronous): parser returns to the header phase, both
// registers empty. An end-of-packet byte, once parsed, resets only the parser.
// Receiver stall: the result register holds its beat; the input register
// still drains into it when it empties, so s_ready drops only while both
// registers are full and m_ready is low.
module dns_answer_address_extractor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dae_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dae_pkg::out_beat_t m_data
);

    logic                in_valid_reg;
    dae_pkg::in_beat_t   in_data_reg;
    logic                out_free;
    logic                step;
    dae_pkg::parse_res_t res;

    // Advance the held byte whenever the result register can take it
    assign step    = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    dae_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .beat    (in_data_reg),
        .res     (res)
    );

    dae_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .res     (res),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
